[src/transfer_frame_deframer_macros.svh]
// assertion macros for the transfer frame deframer
// expects clk and rst_n in the scope of use
`ifndef TRANSFER_FRAME_DEFRAMER_MACROS_SVH
`define TRANSFER_FRAME_DEFRAMER_MACROS_SVH

// condition holds in the same cycle
`define TFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfd assertion failed");

// condition holds in the next cycle
`define TFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfd assertion failed");

`endif

[src/tfd_pkg.sv]
// shared types and constants for the transfer frame deframer
// used by the front, back and top modules, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

  localparam int BLOCK_BYTES_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int POS_EXT_W       = 9;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 8;

  localparam logic [3:0] LEN_HI_MASK = 4'hf;

  localparam logic [CFG_IDX_W-1:0] REG_START_ONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TWO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_ONE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_TWO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END        = 3'd4;

  localparam logic [7:0] START_ONE_RST  = 8'hA5;
  localparam logic [7:0] START_TWO_RST  = 8'h5A;
  localparam logic [7:0] RECORD_ONE_RST = 8'h0F;
  localparam logic [7:0] RECORD_TWO_RST = 8'hF0;
  localparam logic [7:0] END_RST        = 8'h84;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_ERASE  = 3'd1;
  localparam logic [2:0] ACT_SAVE   = 3'd2;
  localparam logic [2:0] ACT_APPEND = 3'd3;
  localparam logic [2:0] ACT_SYNC   = 3'd4;

  localparam logic [1:0] WD_NONE   = 2'd0;
  localparam logic [1:0] WD_ARM    = 2'd1;
  localparam logic [1:0] WD_KICK   = 2'd2;
  localparam logic [1:0] WD_DISARM = 2'd3;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       write_valid;
    logic [4:0] write_index;
    logic [7:0] write_byte;
    logic [2:0] block_action;
    logic [5:0] block_len;
    logic [1:0] watchdog_action;
    logic       frame_error;
  } out_t;

  typedef struct packed {
    logic       abort;
    logic [7:0] rx_byte;
    logic       hit_start_one;
    logic       hit_start_two;
    logic       hit_record_one;
    logic       hit_record_two;
    logic       hit_end;
  } cls_t;

endpackage

`default_nettype wire

[src/tfd_fifo.sv]
// small register queue used between the stages and at the result side
// generic over width and depth, no package dependency
`timescale 1ns / 1ps
`default_nettype none

module tfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/tfd_front.sv]
// front stage: marker registers and byte classification
// depends on tfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfd_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire tfd_pkg::in_t                   in_data,
  output tfd_pkg::cls_t                       cls
);

  logic [7:0] start_one_r, start_two_r, record_one_r, record_two_r, end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_one_r  <= tfd_pkg::START_ONE_RST;
      start_two_r  <= tfd_pkg::START_TWO_RST;
      record_one_r <= tfd_pkg::RECORD_ONE_RST;
      record_two_r <= tfd_pkg::RECORD_TWO_RST;
      end_r        <= tfd_pkg::END_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tfd_pkg::REG_START_ONE:  start_one_r  <= cfg_data;
        tfd_pkg::REG_START_TWO:  start_two_r  <= cfg_data;
        tfd_pkg::REG_RECORD_ONE: record_one_r <= cfg_data;
        tfd_pkg::REG_RECORD_TWO: record_two_r <= cfg_data;
        tfd_pkg::REG_END:        end_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cls.abort          = in_data.mode;
    cls.rx_byte        = in_data.rx_byte;
    cls.hit_start_one  = (in_data.rx_byte == start_one_r);
    cls.hit_start_two  = (in_data.rx_byte == start_two_r);
    cls.hit_record_one = (in_data.rx_byte == record_one_r);
    cls.hit_record_two = (in_data.rx_byte == record_two_r);
    cls.hit_end        = (in_data.rx_byte == end_r);
  end

endmodule

`default_nettype wire

[src/tfd_back.sv]
// back stage: frame parser state machine, block and watchdog cues
// depends on tfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module tfd_back #(
  parameter int BLOCK_BYTES = tfd_pkg::BLOCK_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          mid_empty,
  input  wire tfd_pkg::cls_t mid_item,
  output logic               mid_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output tfd_pkg::out_t      res_item
);

  localparam int POS_W = $clog2(BLOCK_BYTES + 1);

  typedef enum logic [9:0] {
    ST_START1 = 10'b0000000001,
    ST_START2 = 10'b0000000010,
    ST_NEXT   = 10'b0000000100,
    ST_PAT2   = 10'b0000001000,
    ST_HDR1   = 10'b0000010000,
    ST_HDR2   = 10'b0000100000,
    ST_META1  = 10'b0001000000,
    ST_META2  = 10'b0010000000,
    ST_FIRST  = 10'b0100000000,
    ST_DATA   = 10'b1000000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [11:0]                   left_r, left_nxt;
  logic                          go;
  logic                          in_record;
  logic [tfd_pkg::POS_EXT_W-1:0] idx_ext, len_ext;

  assign go       = !mid_empty && !res_full;
  assign mid_pop  = go;
  assign res_push = go;

  assign in_record = (state_r == ST_HDR1) || (state_r == ST_HDR2) ||
                     (state_r == ST_META1) || (state_r == ST_META2) ||
                     (state_r == ST_FIRST) || (state_r == ST_DATA);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    res_item  = '0;
    idx_ext   = tfd_pkg::POS_EXT_W'(pos_r);
    len_ext   = '0;
    if (mid_item.abort) begin
      state_nxt                = ST_START1;
      res_item.watchdog_action = tfd_pkg::WD_DISARM;
    end else begin
      if (in_record) begin
        res_item.write_valid = 1'b1;
        res_item.write_index = idx_ext[4:0];
        res_item.write_byte  = mid_item.rx_byte;
        pos_nxt              = pos_r + 1'b1;
        if ((state_r == ST_FIRST) || (state_r == ST_DATA)) begin
          left_nxt = left_r - 1'b1;
        end
      end
      len_ext = tfd_pkg::POS_EXT_W'(pos_nxt);
      case (state_r)
        ST_START1: begin
          if (mid_item.hit_start_one) state_nxt = ST_START2;
        end
        ST_START2: begin
          if (mid_item.hit_start_two) begin
            state_nxt                = ST_NEXT;
            res_item.block_action    = tfd_pkg::ACT_ERASE;
            res_item.watchdog_action = tfd_pkg::WD_ARM;
          end else if (!mid_item.hit_start_one) begin
            state_nxt            = ST_START1;
            res_item.frame_error = 1'b1;
          end
        end
        ST_NEXT: begin
          if (mid_item.hit_record_one) begin
            state_nxt = ST_PAT2;
          end else if (mid_item.hit_end) begin
            state_nxt                = ST_START1;
            res_item.block_action    = tfd_pkg::ACT_SYNC;
            res_item.watchdog_action = tfd_pkg::WD_DISARM;
          end else begin
            state_nxt            = ST_START1;
            res_item.frame_error = 1'b1;
          end
        end
        ST_PAT2: begin
          if (mid_item.hit_record_two) begin
            state_nxt = ST_HDR1;
            pos_nxt   = '0;
          end else begin
            state_nxt            = ST_START1;
            res_item.frame_error = 1'b1;
          end
        end
        ST_HDR1: begin
          state_nxt = ST_HDR2;
          left_nxt  = {mid_item.rx_byte[3:0] & tfd_pkg::LEN_HI_MASK, 8'h00};
        end
        ST_HDR2: begin
          state_nxt                = ST_META1;
          left_nxt                 = left_r + 12'(mid_item.rx_byte);
          res_item.watchdog_action = tfd_pkg::WD_KICK;
        end
        ST_META1: begin
          state_nxt = ST_META2;
        end
        ST_META2: begin
          state_nxt = (left_r == '0) ? ST_NEXT : ST_FIRST;
        end
        ST_FIRST: begin
          if (left_nxt == '0) begin
            state_nxt             = ST_NEXT;
            res_item.block_action = tfd_pkg::ACT_SAVE;
            res_item.block_len    = len_ext[5:0];
          end else if (pos_nxt >= POS_W'(BLOCK_BYTES)) begin
            state_nxt             = ST_DATA;
            res_item.block_action = tfd_pkg::ACT_SAVE;
            res_item.block_len    = len_ext[5:0];
            pos_nxt               = '0;
          end
        end
        ST_DATA: begin
          if (left_nxt == '0) begin
            state_nxt             = ST_NEXT;
            res_item.block_action = tfd_pkg::ACT_APPEND;
            res_item.block_len    = len_ext[5:0];
          end else if (pos_nxt >= POS_W'(BLOCK_BYTES)) begin
            res_item.block_action    = tfd_pkg::ACT_APPEND;
            res_item.block_len       = len_ext[5:0];
            res_item.watchdog_action = tfd_pkg::WD_KICK;
            pos_nxt                  = '0;
          end
        end
        default: begin
          state_nxt = ST_START1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START1;
      pos_r   <= '0;
      left_r  <= '0;
    end else if (go) begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

`default_nettype wire

[src/transfer_frame_deframer.sv]
// transfer frame deframer top level: front classifier, queue, parser, result queue
// depends on tfd_pkg, tfd_fifo, tfd_front, tfd_back and the macros header
//
//   channel  ports                           transaction
//   input    in_push in_full in_data         push && !full, one byte or abort
//   result   out_pop out_empty out_data      pop && !empty, one result per input
//   config   cfg_we cfg_index cfg_data       every cycle cfg_we is high
//
// one transaction per cycle sustained while neither queue stalls the parser
// an input reaches the result side through the classify queue, then the result queue
// each side stalls on its own through a two-entry queue
// synchronous active-low reset restores the marker registers and the hunt state
`timescale 1ns / 1ps
`default_nettype none

`include "transfer_frame_deframer_macros.svh"

module transfer_frame_deframer #(
  parameter int BLOCK_BYTES = tfd_pkg::BLOCK_BYTES_DEF,
  parameter int QUEUE_DEPTH = tfd_pkg::QUEUE_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire tfd_pkg::in_t                   in_data,
  output logic                                in_full,
  input  wire logic                           out_pop,
  output tfd_pkg::out_t                       out_data,
  output logic                                out_empty,
  input  wire logic                           cfg_we,
  input  wire logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  tfd_pkg::cls_t cls;
  tfd_pkg::cls_t mid_item;
  tfd_pkg::out_t res_item;
  logic          mid_empty, mid_pop;
  logic          res_full, res_push;
  logic          out_live, idle_clean, commit_act, quiet_res;

  tfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cls       (cls)
  );

  tfd_fifo #(
    .WIDTH ($bits(tfd_pkg::cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (cls),
    .full      (in_full),
    .pop       (mid_pop),
    .pop_data  (mid_item),
    .empty     (mid_empty)
  );

  tfd_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_item),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  tfd_fifo #(
    .WIDTH ($bits(tfd_pkg::out_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_item),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

  assign out_live   = !out_empty;
  assign idle_clean = (out_data.write_index == 5'd0) && (out_data.write_byte == 8'd0);
  assign commit_act = (out_data.block_action == tfd_pkg::ACT_SAVE) ||
                      (out_data.block_action == tfd_pkg::ACT_APPEND);
  assign quiet_res  = !out_data.write_valid && (out_data.block_action == tfd_pkg::ACT_NONE);

  // no write means zeroed index and byte
  `TFD_ASSERT_NOW(a_idle_write, out_live && !out_data.write_valid, idle_clean)
  // length only with a save or append
  `TFD_ASSERT_NOW(a_len_commit, out_live && !commit_act, out_data.block_len == 6'd0)
  // a resync carries no write and no commit
  `TFD_ASSERT_NOW(a_err_quiet, out_live && out_data.frame_error, quiet_res)
  // result queue cannot drain while nothing was popped
  `TFD_ASSERT_NEXT(a_hold_result, out_live && !out_pop, !out_empty)

endmodule

`default_nettype wire
